[src/acfp_pkg.sv]
package acfp_pkg;

    // Frame characters
    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
    localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_GET   = 8'h67;  // 'g'
    localparam logic [7:0] CH_SET   = 8'h73;  // 's'
    localparam logic [7:0] CH_T     = 8'h74;  // 't'
    localparam logic [7:0] CH_A     = 8'h61;  // 'a'
    localparam logic [7:0] CH_C     = 8'h63;  // 'c'
    localparam logic [7:0] CH_P     = 8'h70;  // 'p'
    localparam logic [7:0] CH_I     = 8'h69;  // 'i'
    localparam logic [7:0] CH_D     = 8'h64;  // 'd'

    // Parameter codes
    localparam logic [2:0] PC_TEMP   = 3'd0;
    localparam logic [2:0] PC_HEATER = 3'd1;
    localparam logic [2:0] PC_COOLER = 3'd2;
    localparam logic [2:0] PC_KP     = 3'd3;
    localparam logic [2:0] PC_KI     = 3'd4;
    localparam logic [2:0] PC_KD     = 3'd5;

    // Value buffer geometry: the result word carries at most seven bytes
    localparam int unsigned STORE_DEPTH     = 7;
    localparam int unsigned MAX_VALUE_CHARS = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READY,
        ST_GET,
        ST_SET,
        ST_PARAM,
        ST_VALUE
    } t_parse_state;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic        is_set;
        logic [2:0]  param_code;
        logic [2:0]  value_length;
        logic [55:0] value_bytes;
    } t_out_word;

    // Parser result toward the output register
    typedef struct packed {
        logic      emit;
        t_out_word word;
    } t_parse_res;

    typedef struct packed {
        logic       hit;
        logic [2:0] code;
    } t_letter;

    function automatic t_letter letter_code(input logic [7:0] b);
        t_letter l;
        l.hit = 1'b1;
        case (b)
            CH_T:    l.code = PC_TEMP;
            CH_A:    l.code = PC_HEATER;
            CH_C:    l.code = PC_COOLER;
            CH_P:    l.code = PC_KP;
            CH_I:    l.code = PC_KI;
            CH_D:    l.code = PC_KD;
            default: begin
                l.hit  = 1'b0;
                l.code = PC_TEMP;
            end
        endcase
        return l;
    endfunction

endpackage

[src/acfp_chan_if.sv]
interface acfp_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[src/acfp_in_reg.sv]
module acfp_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    acfp_chan_if.sink         i_rx,
    input  logic              i_take,
    output logic              o_valid,
    output acfp_pkg::t_in_word o_word
);
    logic               r_valid;
    acfp_pkg::t_in_word r_word;
    logic               accept;

    // Slot frees up in the same cycle the parser consumes the held word
    assign i_rx.ready = !r_valid || i_take;
    assign accept     = i_rx.valid && i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= i_rx.payload;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
endmodule

[src/acfp_parser.sv]
module acfp_parser #(
    parameter int unsigned MAX_VALUE_CHARS = acfp_pkg::MAX_VALUE_CHARS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  acfp_pkg::t_in_word   i_word,
    input  logic                 i_out_free,
    output logic                 o_take,
    output acfp_pkg::t_parse_res o_res
);
    localparam int unsigned LIMIT = (MAX_VALUE_CHARS > acfp_pkg::STORE_DEPTH) ?
                                    acfp_pkg::STORE_DEPTH : MAX_VALUE_CHARS;
    localparam logic [2:0]  LIMIT_CNT = 3'(LIMIT);

    acfp_pkg::t_parse_state r_state, n_state;
    logic [2:0]             r_param;
    logic [2:0]             r_count;
    logic [7:0]             r_store [LIMIT];

    logic [7:0]        b;
    acfp_pkg::t_letter letter;
    logic              is_val_char;
    logic              set_letter;
    logic              emit;
    logic              load_param;
    logic              clear_count;
    logic              store_char;
    logic [55:0]       bytes;

    assign b           = i_word.rx_byte;
    assign letter      = acfp_pkg::letter_code(b);
    assign is_val_char = ((b >= acfp_pkg::CH_ZERO) && (b <= acfp_pkg::CH_NINE)) ||
                         (b == acfp_pkg::CH_COMMA);
    // set frames only take t, p, i, d
    assign set_letter  = letter.hit && (letter.code != acfp_pkg::PC_HEATER) &&
                         (letter.code != acfp_pkg::PC_COOLER);

    // Next state
    always_comb begin
        n_state = acfp_pkg::ST_IDLE;
        if (b == acfp_pkg::CH_HASH) begin
            n_state = acfp_pkg::ST_READY;
        end else begin
            unique case (r_state)
                acfp_pkg::ST_READY: begin
                    if (b == acfp_pkg::CH_GET) begin
                        n_state = acfp_pkg::ST_GET;
                    end else if (b == acfp_pkg::CH_SET) begin
                        n_state = acfp_pkg::ST_SET;
                    end
                end
                acfp_pkg::ST_GET: begin
                    if (letter.hit) begin
                        n_state = acfp_pkg::ST_PARAM;
                    end
                end
                acfp_pkg::ST_SET: begin
                    if (set_letter) begin
                        n_state = acfp_pkg::ST_VALUE;
                    end
                end
                acfp_pkg::ST_VALUE: begin
                    if (is_val_char) begin
                        n_state = acfp_pkg::ST_VALUE;
                    end
                end
                default: n_state = acfp_pkg::ST_IDLE;
            endcase
        end
    end

    // Outputs and datapath strobes
    always_comb begin
        emit        = 1'b0;
        load_param  = 1'b0;
        clear_count = 1'b0;
        store_char  = 1'b0;
        if (b != acfp_pkg::CH_HASH) begin
            unique case (r_state)
                acfp_pkg::ST_GET: load_param = letter.hit;
                acfp_pkg::ST_SET: begin
                    load_param  = set_letter;
                    clear_count = set_letter;
                end
                acfp_pkg::ST_PARAM: emit = (b == acfp_pkg::CH_SEMI);
                acfp_pkg::ST_VALUE: begin
                    store_char = is_val_char && (r_count < LIMIT_CNT);
                    emit       = (b == acfp_pkg::CH_SEMI);
                end
                default: ;
            endcase
        end
    end

    // Collected bytes, masked above the fill count
    for (genvar k = 0; k < acfp_pkg::STORE_DEPTH; k++) begin : g_bytes
        if (k < LIMIT) begin : g_used
            assign bytes[8*k +: 8] = (3'(k) < r_count) ? r_store[k] : 8'h00;
        end else begin : g_unused
            assign bytes[8*k +: 8] = 8'h00;
        end
    end

    always_comb begin
        o_res.emit              = i_valid && emit;
        o_res.word.param_code   = r_param;
        if (r_state == acfp_pkg::ST_VALUE) begin
            o_res.word.is_set       = 1'b1;
            o_res.word.value_length = r_count;
            o_res.word.value_bytes  = bytes;
        end else begin
            o_res.word.is_set       = 1'b0;
            o_res.word.value_length = 3'd0;
            o_res.word.value_bytes  = '0;
        end
    end

    // Only a byte that closes a frame waits on the output register
    assign o_take = i_valid && (!emit || i_out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= acfp_pkg::ST_IDLE;
            r_param <= acfp_pkg::PC_TEMP;
            r_count <= 3'd0;
        end else if (o_take) begin
            r_state <= n_state;
            if (load_param) begin
                r_param <= letter.code;
            end
            if (clear_count) begin
                r_count <= 3'd0;
            end else if (store_char) begin
                r_count <= r_count + 3'd1;
            end
        end
    end

    for (genvar k = 0; k < LIMIT; k++) begin : g_store
        always_ff @(posedge i_clk) begin
            if (o_take && store_char && (r_count == 3'(k))) begin
                r_store[k] <= b;
            end
        end
    end

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LIMIT_CNT)
        else $error("value count past limit");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && emit) |-> i_out_free)
        else $error("result taken with output register full");

    a_get_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.emit && !o_res.word.is_set) |->
        (o_res.word.value_length == 3'd0 && o_res.word.value_bytes == '0))
        else $error("get result carries value bytes");

    a_hash_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && b == acfp_pkg::CH_HASH) |=> (r_state == acfp_pkg::ST_READY))
        else $error("hash did not restart frame");
endmodule

[src/acfp_out_reg.sv]
module acfp_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  acfp_pkg::t_out_word  i_word,
    output logic                 o_free,
    acfp_chan_if.source          o_cmd
);
    logic                r_valid;
    acfp_pkg::t_out_word r_word;

    assign o_free = !r_valid || o_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_cmd.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_cmd.valid   = r_valid;
    assign o_cmd.payload = r_word;
endmodule

[src/ascii_command_frame_parser.sv]
// ASCII command frame parser.
// i_rx (sink): one received byte per word, payload field rx_byte.
// o_cmd (source): one word per complete frame: is_set, param_code,
//   value_length and value_bytes (first value character in the low byte,
//   bytes past value_length are zero; all zero for a get).
// Get frame '#','g',<t|a|c|p|i|d>,';'. Set frame '#','s',<t|p|i|d>, digits
// or commas, ';'. Value characters past the limit are dropped and the length
// saturates. A '#' restarts a frame anywhere; any other bad byte drops to idle.
// Throughput: one byte per cycle, sustained unless a closing byte waits on
// the output register. The parser updates its state once per consumed byte
// between the input and output registers; a closing ';' passes through both
// before it shows on o_cmd. Stall: while o_cmd is held off, bytes that do
// not close a frame still flow through; a closing byte waits in the input
// register until the output register frees, and i_rx.ready is low meanwhile.
// Reset (i_rst_n low, synchronous): parser idle, both registers empty.
// The value buffer is not cleared; only bytes of the current frame are read.
module ascii_command_frame_parser #(
    parameter int unsigned MAX_VALUE_CHARS = acfp_pkg::MAX_VALUE_CHARS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    acfp_chan_if.sink   i_rx,
    acfp_chan_if.source o_cmd
);
    // input register -> parser
    logic                 in_valid;
    acfp_pkg::t_in_word   in_word;
    logic                 take;

    // parser -> output register
    acfp_pkg::t_parse_res res;
    logic                 out_free;

    acfp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (take),
        .o_valid (in_valid),
        .o_word  (in_word)
    );

    acfp_parser #(
        .MAX_VALUE_CHARS (MAX_VALUE_CHARS)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .i_word     (in_word),
        .i_out_free (out_free),
        .o_take     (take),
        .o_res      (res)
    );

    // A result is loaded only when its closing byte is actually consumed
    acfp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take && res.emit),
        .i_word  (res.word),
        .o_free  (out_free),
        .o_cmd   (o_cmd)
    );
endmodule
